// ===== src/bc4_pkg.sv =====
package bc4_pkg;

  localparam int NumSamples  = 16;
  localparam int SampleWidth = 8;
  localparam int IndexWidth  = 3;
  localparam int LevelWidth  = 3;
  // 7 * 255 + 127 fits in 11 bits.
  localparam int AccWidth    = 11;
  localparam int DistWidth   = SampleWidth;

  localparam int InDataWidth  = 2 * 64;
  localparam int OutDataWidth = 2 * SampleWidth + NumSamples * IndexWidth;

  localparam logic [LevelWidth-1:0] LevelMin = 3'd0;
  localparam logic [LevelWidth-1:0] LevelMax = 3'd7;

  typedef logic [NumSamples-1:0][SampleWidth-1:0] sample_arr_t;
  typedef logic [3:0][SampleWidth-1:0]            quad_arr_t;
  typedef logic [NumSamples-1:0][AccWidth-1:0]    acc_arr_t;
  typedef logic [NumSamples-1:0][LevelWidth-1:0]  level_arr_t;
  typedef logic [NumSamples-1:0][IndexWidth-1:0]  index_arr_t;

  // Level 0 selects the min endpoint (index 1), the top level selects the max
  // endpoint (index 0), and the levels between map to indices 7 down to 2.
  function automatic logic [IndexWidth-1:0] level_to_index(input logic [LevelWidth-1:0] level);
    logic [IndexWidth-1:0] ix;
    ix = IndexWidth'(4'd8 - {1'b0, level});
    if (level == LevelMin) begin
      ix = 3'd1;
    end else if (level == LevelMax) begin
      ix = 3'd0;
    end
    return ix;
  endfunction

endpackage

// ===== src/bc4_block_encoder.sv =====
// BC4 block encoder: one 4x4 block of sixteen 8-bit samples in, one
// compressed block out.
// Input channel s_*: one beat carries a whole block in s_tdata (128 bits).
// Output channel m_*: one beat carries both endpoints and the sixteen
// 3-bit palette indices in m_tdata (64 bits).
// The block is a five-stage pipeline: a min/max tree over two stages, the
// scaled sample distance, then the three threshold steps over two stages,
// the last of which is the output register. A new block is accepted every
// cycle unless every stage holds a block and the receiver stalls.
// Each stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up while the receiver stalls and the
// block keeps accepting until every stage holds a block.
// A stall loses and repeats nothing: a held stage keeps its data.
// Reset (rst, synchronous) clears all valid bits; no block is in flight
// afterwards and s_tready is high in the first cycle after reset.
module bc4_block_encoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // samples_low [63:0], samples_high [127:64]
  input  logic [bc4_pkg::InDataWidth-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // endpoint_max [7:0], endpoint_min [15:8], packed_indices [63:16]
  output logic [bc4_pkg::OutDataWidth-1:0] m_tdata
);

  localparam int W = bc4_pkg::SampleWidth;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Stage 1: samples and the min/max of each group of four.
  bc4_pkg::sample_arr_t in_samples;
  bc4_pkg::quad_arr_t   quad_min_next, quad_max_next;
  bc4_pkg::sample_arr_t s1_samples;
  bc4_pkg::quad_arr_t   s1_min, s1_max;

  assign in_samples = s_tdata;

  always_comb begin
    logic [W-1:0] ma, mb, xa, xb;
    for (int q = 0; q < 4; q++) begin
      ma = (in_samples[4*q]   < in_samples[4*q+1]) ? in_samples[4*q]   : in_samples[4*q+1];
      mb = (in_samples[4*q+2] < in_samples[4*q+3]) ? in_samples[4*q+2] : in_samples[4*q+3];
      xa = (in_samples[4*q]   > in_samples[4*q+1]) ? in_samples[4*q]   : in_samples[4*q+1];
      xb = (in_samples[4*q+2] > in_samples[4*q+3]) ? in_samples[4*q+2] : in_samples[4*q+3];
      quad_min_next[q] = (ma < mb) ? ma : mb;
      quad_max_next[q] = (xa > xb) ? xa : xb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_samples <= in_samples;
      s1_min     <= quad_min_next;
      s1_max     <= quad_max_next;
    end
  end

  // Stage 2: block min and max.
  logic [W-1:0] lo_next, hi_next;
  bc4_pkg::sample_arr_t s2_samples;
  logic [W-1:0] s2_lo, s2_hi;

  always_comb begin
    logic [W-1:0] m0, m1, x0, x1;
    m0 = (s1_min[0] < s1_min[1]) ? s1_min[0] : s1_min[1];
    m1 = (s1_min[2] < s1_min[3]) ? s1_min[2] : s1_min[3];
    x0 = (s1_max[0] > s1_max[1]) ? s1_max[0] : s1_max[1];
    x1 = (s1_max[2] > s1_max[3]) ? s1_max[2] : s1_max[3];
    lo_next = (m0 < m1) ? m0 : m1;
    hi_next = (x0 > x1) ? x0 : x1;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_samples <= s1_samples;
      s2_lo      <= lo_next;
      s2_hi      <= hi_next;
    end
  end

  // Stage 3: a = 7*(s - min) + dist/2, which equals 7*s - bias and is never
  // negative because every sample is at least the minimum.
  logic [bc4_pkg::DistWidth-1:0] dist_next;
  bc4_pkg::acc_arr_t acc3_next;
  bc4_pkg::acc_arr_t s3_acc;
  logic [bc4_pkg::DistWidth-1:0] s3_dist;
  logic [W-1:0] s3_lo, s3_hi;

  assign dist_next = s2_hi - s2_lo;

  always_comb begin
    logic [W-1:0] d;
    for (int i = 0; i < bc4_pkg::NumSamples; i++) begin
      d = s2_samples[i] - s2_lo;
      acc3_next[i] = ({3'b000, d} << 3) - {3'b000, d}
                   + {4'b0000, dist_next[W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_acc  <= acc3_next;
      s3_dist <= dist_next;
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
    end
  end

  // Stage 4: first threshold step against 4*dist.
  logic [bc4_pkg::AccWidth-1:0] dist4;
  bc4_pkg::acc_arr_t acc4_next;
  logic [bc4_pkg::NumSamples-1:0] bit2_next;
  bc4_pkg::acc_arr_t s4_acc;
  logic [bc4_pkg::NumSamples-1:0] s4_bit2;
  logic [bc4_pkg::DistWidth-1:0] s4_dist;
  logic [W-1:0] s4_lo, s4_hi;

  assign dist4 = {1'b0, s3_dist, 2'b00};

  always_comb begin
    for (int i = 0; i < bc4_pkg::NumSamples; i++) begin
      bit2_next[i] = s3_acc[i] > dist4;
      acc4_next[i] = bit2_next[i] ? s3_acc[i] - dist4 : s3_acc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_acc  <= acc4_next;
      s4_bit2 <= bit2_next;
      s4_dist <= s3_dist;
      s4_lo   <= s3_lo;
      s4_hi   <= s3_hi;
    end
  end

  // Stage 5: steps against 2*dist and dist, then the level-to-index map.
  logic [bc4_pkg::AccWidth-1:0] dist2, dist1;
  bc4_pkg::index_arr_t idx_next;
  bc4_pkg::index_arr_t s5_idx;
  logic [W-1:0] s5_lo, s5_hi;

  assign dist2 = {2'b00, s4_dist, 1'b0};
  assign dist1 = {3'b000, s4_dist};

  always_comb begin
    logic [bc4_pkg::AccWidth-1:0] a;
    logic b1, b0;
    for (int i = 0; i < bc4_pkg::NumSamples; i++) begin
      b1 = s4_acc[i] > dist2;
      a  = b1 ? s4_acc[i] - dist2 : s4_acc[i];
      b0 = a > dist1;
      idx_next[i] = bc4_pkg::level_to_index({s4_bit2[i], b1, b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_idx <= idx_next;
      s5_lo  <= s4_lo;
      s5_hi  <= s4_hi;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {s5_idx, s5_lo, s5_hi};

endmodule
